FILE: sv/multilevel_process_queue_unit_defines.svh
// Assertion macros for the multilevel process queue unit.
// Used by the top level only; needs no other file.
`ifndef MULTILEVEL_PROCESS_QUEUE_UNIT_DEFINES_SVH
`define MULTILEVEL_PROCESS_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/mpq_pkg.sv
// Package for the multilevel process queue: sizes, codes, word and control types.
// Used by mpq_ctrl, mpq_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 32;

    localparam int LVL_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int EN_W   = 4;
    localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int ID_W    = 22;
    localparam int LEVEL_W = 4;
    localparam int CFG_W   = 3;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic signed [LEVEL_W-1:0] NULL_LEVEL = -4'sd1;
    localparam logic [CFG_W-1:0]          QIU_RESET  = 3'd1;

    typedef struct packed {
        logic [2:0]                operation;
        logic [ID_W-1:0]           proc_id;
        logic signed [LEVEL_W-1:0] proc_level;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                status;
        logic [ID_W-1:0]           out_id;
        logic signed [LEVEL_W-1:0] out_level;
    } t_out_word;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/mpq_ctrl.sv
// Controller of the multilevel process queue: accept, execute, deliver sequence.
// Depends on mpq_pkg for the command and status types.
`timescale 1ns / 1ps

module mpq_ctrl import mpq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mpq_datapath.sv
// Datapath of the multilevel process queue: slot memory, ring pointers,
// level scan, config register and output register. Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_datapath import mpq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_stat,
    input  t_in_word         i_in_word,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word
);

    logic [ID_W-1:0] mem [SLOTS];

    t_in_word         r_in;
    logic [CFG_W-1:0] r_qiu;
    logic [PTR_W-1:0] r_head [NUM_QUEUES];
    logic [CNT_W-1:0] r_fill [NUM_QUEUES];
    logic [ID_W-1:0]  r_rdata;
    logic [1:0]       r_st;
    logic signed [LEVEL_W-1:0] r_lvl;
    logic             r_use_rd;
    logic             r_out_valid;
    t_out_word        r_out;

    logic [EN_W-1:0]   enabled;
    logic [LVL_W-1:0]  act_q;
    logic [LVL_W-1:0]  ins_q;
    logic              bad_lvl;
    logic              ins_full;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  back_sum;
    logic [PTR_W-1:0]  tail_pos;
    logic [PTR_W-1:0]  back_pos;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              do_write;
    logic              do_pop_front;
    logic              do_pop_back;
    logic [1:0]        n_st;
    logic signed [LEVEL_W-1:0] n_lvl;
    logic              n_use_rd;

    always_comb begin
        enabled = (EN_W'(r_qiu) > EN_W'(NUM_QUEUES)) ? EN_W'(NUM_QUEUES) : EN_W'(r_qiu);
        act_q   = '0;
        for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
            if ((EN_W'(q) < enabled) && (r_fill[q] != '0)) begin
                act_q = LVL_W'(q);
            end
        end
    end

    always_comb begin
        ins_q    = r_in.proc_level[LVL_W-1:0];
        bad_lvl  = r_in.proc_level[LEVEL_W-1] ||
                   (EN_W'(r_in.proc_level[LEVEL_W-2:0]) >= enabled);
        ins_full = (r_fill[ins_q] == CNT_W'(QUEUE_DEPTH));

        tail_sum = SUM_W'(r_head[ins_q]) + SUM_W'(r_fill[ins_q]);
        tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

        back_sum = SUM_W'(r_head[act_q]) + SUM_W'(r_fill[act_q]) - SUM_W'(1);
        back_pos = (back_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   PTR_W'(back_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(back_sum);

        head_next = (SUM_W'(r_head[act_q]) + SUM_W'(1) >= SUM_W'(QUEUE_DEPTH)) ?
                    '0 : PTR_W'(SUM_W'(r_head[act_q]) + SUM_W'(1));

        wr_addr = ADDR_W'(ins_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
    end

    always_comb begin
        n_st         = ST_OK;
        n_lvl        = NULL_LEVEL;
        n_use_rd     = 1'b0;
        do_write     = 1'b0;
        do_pop_front = 1'b0;
        do_pop_back  = 1'b0;
        rd_pos       = r_head[act_q];
        case (r_in.operation)
            OP_INSERT: begin
                if (bad_lvl) begin
                    n_st = ST_BAD;
                end else if (ins_full) begin
                    n_st = ST_FULL;
                end else begin
                    do_write = 1'b1;
                end
            end
            OP_PEEK_FRONT, OP_POP_FRONT, OP_PEEK_BACK, OP_POP_BACK: begin
                if (r_fill[act_q] == '0) begin
                    n_st = ST_EMPTY;
                end else begin
                    n_use_rd     = 1'b1;
                    n_lvl        = LEVEL_W'(act_q);
                    do_pop_front = (r_in.operation == OP_POP_FRONT);
                    do_pop_back  = (r_in.operation == OP_POP_BACK);
                    if (r_in.operation == OP_PEEK_BACK || r_in.operation == OP_POP_BACK) begin
                        rd_pos = back_pos;
                    end
                end
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
        rd_addr = ADDR_W'(act_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_pos);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            mem[wr_addr] <= r_in.proc_id;
        end
        if (i_cmd.exec) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
        if (i_cmd.exec) begin
            r_st     <= n_st;
            r_lvl    <= n_lvl;
            r_use_rd <= n_use_rd;
        end
        if (i_cmd.load_out) begin
            r_out.status    <= r_st;
            r_out.out_id    <= r_use_rd ? r_rdata : '0;
            r_out.out_level <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qiu       <= QIU_RESET;
            r_out_valid <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_fill[q] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_qiu <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                if (do_write) begin
                    r_fill[ins_q] <= r_fill[ins_q] + CNT_W'(1);
                end
                if (do_pop_front) begin
                    r_head[act_q] <= head_next;
                    r_fill[act_q] <= r_fill[act_q] - CNT_W'(1);
                end
                if (do_pop_back) begin
                    r_fill[act_q] <= r_fill[act_q] - CNT_W'(1);
                end
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out;

endmodule

FILE: sv/multilevel_process_queue_unit.sv
// Multilevel process queue: per-level ring FIFOs of process ids with
// insert, peek and pop on the most urgent non-empty level in use.
// Top level; depends on mpq_pkg, mpq_ctrl, mpq_datapath and the defines header.
//
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one operation word.
// Output channel (o_out_valid / i_out_ready / o_out_word) returns one result
// word per operation, in order.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes queues_in_use;
// it is always ready; the user must write it only while the block is idle,
// and the block itself does not enforce this. Each word goes through accept,
// execute (level scan, pointer update and slot memory access), then load of
// the output register; the slot memory read is registered. The next word is
// accepted only once the result has been loaded into the output register.
// A new word is accepted while a finished result still waits in the output
// register; its result waits in the done state until the register frees.
// Synchronous reset empties all levels, zeroes head pointers and sets
// queues_in_use to 1; slot memory contents are not cleared.
`timescale 1ns / 1ps
`include "multilevel_process_queue_unit_defines.svh"

module multilevel_process_queue_unit import mpq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status stat;

    assign o_cfg_ready = 1'b1;

    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mpq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    `MPQ_ASSERT(a_accept_then_exec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (cmd.exec && !o_in_ready), "accepted word not executed next cycle")
    `MPQ_ASSERT(a_load_when_free, i_clk, i_rst_n, cmd.load_out |-> stat.out_free, "output register loaded while occupied")
    `MPQ_ASSERT(a_load_sets_valid, i_clk, i_rst_n, cmd.load_out |=> o_out_valid, "loaded result not presented")

endmodule

FILE: bench/multilevel_process_queue_unit_tb.sv
// Self-checking bench for multilevel_process_queue_unit: directed and random words,
// checked in order against a behavioral queue model kept in a scoreboard class.
// Depends on mpq_pkg and the multilevel_process_queue_unit RTL.
`timescale 1ns / 1ps

module multilevel_process_queue_unit_tb;
    import mpq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

    class queue_scoreboard;
        logic [ID_W-1:0] slot_mem [SLOTS];
        int head [NUM_QUEUES];
        int fill [NUM_QUEUES];
        logic [CFG_W-1:0] levels_on;
        t_out_word expected_q [$];
        int errors;

        function new();
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head[i] = 0;
                fill[i] = 0;
            end
            levels_on = QIU_RESET;
            errors = 0;
        endfunction

        function void set_levels(logic [CFG_W-1:0] v);
            levels_on = v;
        endfunction

        function int enabled();
            return (levels_on > NUM_QUEUES) ? NUM_QUEUES : int'(levels_on);
        endfunction

        function int active();
            for (int q = 0; q < enabled(); q++)
                if (fill[q] != 0) return q;
            return 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            int lvl;
            int q;
            int pos;
            r.status = ST_OK;
            r.out_id = '0;
            r.out_level = NULL_LEVEL;
            case (w.operation)
                OP_INSERT: begin
                    lvl = int'(w.proc_level);
                    if (lvl < 0 || lvl >= enabled()) begin
                        r.status = ST_BAD;
                    end else if (fill[lvl] >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        pos = (head[lvl] + fill[lvl]) % QUEUE_DEPTH;
                        slot_mem[lvl * QUEUE_DEPTH + pos] = w.proc_id;
                        fill[lvl]++;
                    end
                end
                OP_PEEK_FRONT, OP_POP_FRONT, OP_PEEK_BACK, OP_POP_BACK: begin
                    q = active();
                    if (fill[q] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        if (w.operation == OP_PEEK_FRONT || w.operation == OP_POP_FRONT)
                            pos = head[q];
                        else
                            pos = (head[q] + fill[q] - 1) % QUEUE_DEPTH;
                        r.out_id = slot_mem[q * QUEUE_DEPTH + pos];
                        r.out_level = q[LEVEL_W-1:0];
                        if (w.operation == OP_POP_FRONT) begin
                            head[q] = (head[q] + 1) % QUEUE_DEPTH;
                            fill[q]--;
                        end else if (w.operation == OP_POP_BACK) begin
                            fill[q]--;
                        end
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.out_id !== want.out_id ||
                got.out_level !== want.out_level) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d id %h/%h level %0d/%0d (exp/act)",
                             want.status, got.status, want.out_id, got.out_id,
                             want.out_level, got.out_level);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic o_in_ready;
    t_in_word in_word;
    logic o_out_valid;
    logic out_ready;
    t_out_word o_out_word;
    logic cfg_valid;
    logic o_cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    queue_scoreboard sb;
    bit calm;
    int hold_asked;
    int hold_given;
    int hold_left;
    int cycles;
    logic [CFG_W-1:0] cur_levels;

    multilevel_process_queue_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) sb.note_word(in_word);
            if (o_out_valid && out_ready) sb.check_result(o_out_word);
            if (cfg_valid && o_cfg_ready) sb.set_levels(cfg_data);
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else if (hold_asked != hold_given) begin
            hold_given++;
            hold_left = HOLD_CYCLES - 1;
            out_ready = 1'b0;
        end else begin
            out_ready = calm || ($urandom_range(99) >= 13);
        end
    end

    function automatic t_in_word build_word(logic [2:0] op, logic [ID_W-1:0] id,
                                            logic signed [LEVEL_W-1:0] lvl);
        t_in_word w;
        w.operation = op;
        w.proc_id = id;
        w.proc_level = lvl;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(99) < 13) begin
                in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        in_valid = 1'b1;
        in_word = w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_levels(input logic [CFG_W-1:0] v);
        drain();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        cur_levels = v;
    endtask

    task automatic run_phase(input int count, input int insert_pct);
        t_in_word w;
        int pick;
        int top;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            w.proc_id = ID_W'($urandom);
            if (pick < 3)
                w.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else if (pick < 3 + insert_pct)
                w.operation = OP_INSERT;
            else
                w.operation = 3'($urandom_range(OP_PEEK_FRONT, OP_POP_BACK));
            if ($urandom_range(99) < 85) begin
                top = (cur_levels > NUM_QUEUES) ? NUM_QUEUES : int'(cur_levels);
                w.proc_level = LEVEL_W'($urandom_range(0, (top > 0) ? top - 1 : 0));
            end else begin
                w.proc_level = LEVEL_W'($urandom);
            end
            send_word(w);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        out_ready = 1'b0;
        calm = 1'b0;
        hold_asked = 0;
        hold_given = 0;
        hold_left = 0;
        cycles = 0;
        cur_levels = QIU_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(build_word(OP_INSERT, 22'h2AAAAA, 4'sd1));
        send_word(build_word(OP_INSERT, 22'h000001, 4'sd0));
        send_word(build_word(OP_POP_FRONT, '0, 4'sd0));

        write_levels(3'd4);
        send_word(build_word(OP_POP_FRONT, '0, 4'sd0));
        send_word(build_word(OP_PEEK_FRONT, '1, -4'sd1));
        send_word(build_word(OP_PEEK_BACK, '0, 4'sd0));
        send_word(build_word(OP_POP_BACK, '0, 4'sd0));
        send_word(build_word(OP_INSERT, 22'h3FFFFF, 4'sd3));
        send_word(build_word(OP_INSERT, 22'h000000, 4'sd0));
        send_word(build_word(OP_INSERT, 22'h155555, 4'sd1));
        send_word(build_word(OP_INSERT, 22'h123456, -4'sd1));
        send_word(build_word(OP_INSERT, 22'h123456, -4'sd8));
        send_word(build_word(OP_INSERT, 22'h123456, 4'sd7));
        send_word(build_word(OP_INSERT, 22'h123456, 4'sd4));
        send_word(build_word(OP_UNUSED_LO, '1, 4'sd0));
        send_word(build_word(OP_UNUSED_MID, '0, 4'sd2));
        send_word(build_word(OP_UNUSED_HI, '1, -4'sd1));
        send_word(build_word(OP_PEEK_FRONT, '0, 4'sd0));
        send_word(build_word(OP_POP_BACK, '0, 4'sd0));
        send_word(build_word(OP_PEEK_BACK, '0, 4'sd0));
        send_word(build_word(OP_POP_FRONT, '0, 4'sd0));
        send_word(build_word(OP_PEEK_FRONT, '0, 4'sd0));
        send_word(build_word(OP_POP_FRONT, '0, 4'sd0));
        send_word(build_word(OP_POP_FRONT, '0, 4'sd0));

        write_levels(3'd1);
        run_phase(50, 87);

        write_levels(3'd4);
        calm = 1'b1;
        run_phase(60, 50);
        calm = 1'b0;

        write_levels(3'd0);
        run_phase(30, 40);

        write_levels(3'd7);
        hold_asked++;
        run_phase(60, 70);

        write_levels(3'd2);
        run_phase(60, 30);

        write_levels(3'd3);
        run_phase(30, 60);
        drain();
        run_phase(30, 60);

        write_levels(3'd4);
        run_phase(80, 85);

        write_levels(3'd5);
        run_phase(80, 20);

        write_levels(3'd1);
        run_phase(60, 50);

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
